// File: rtl/core/tsmode_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session mode controller package
// Mode, button and message codes plus the request, response and state types.
// ----------------------------------------------------------------------------
package tsmode_pkg;

    typedef enum logic [2:0] {
        M_OFFLINE  = 3'd0,
        M_IDLE     = 3'd1,
        M_HOMING   = 3'd2,
        M_AWAITING = 3'd3,
        M_ENGAGED  = 3'd4,
        M_PAUSED   = 3'd5
    } t_mode;

    // Button codes
    localparam logic [2:0] B_START     = 3'd1;
    localparam logic [2:0] B_ENGAGE    = 3'd2;
    localparam logic [2:0] B_RESET_L   = 3'd3;
    localparam logic [2:0] B_RESET_R   = 3'd4;
    localparam logic [2:0] B_RESET_ALL = 3'd5;

    // Event devices
    localparam logic [1:0] DEV_LEFT  = 2'd0;
    localparam logic [1:0] DEV_RIGHT = 2'd1;

    // State requests to the robot
    localparam logic [2:0] REQ_NONE    = 3'd0;
    localparam logic [2:0] REQ_IDLE    = 3'd1;
    localparam logic [2:0] REQ_HOMING  = 3'd2;
    localparam logic [2:0] REQ_ENGAGED = 3'd3;
    localparam logic [2:0] REQ_PAUSED  = 3'd4;

    // Arm messages
    localparam logic [2:0] MSG_NONE     = 3'd0;
    localparam logic [2:0] MSG_RESET_L  = 3'd1;
    localparam logic [2:0] MSG_RESET_R  = 3'd2;
    localparam logic [2:0] MSG_RESET_AL = 3'd3;
    localparam logic [2:0] MSG_RESUME_L = 3'd4;
    localparam logic [2:0] MSG_RESUME_R = 3'd5;

    // Origin captures
    localparam logic [1:0] CAP_NONE  = 2'd0;
    localparam logic [1:0] CAP_LEFT  = 2'd1;
    localparam logic [1:0] CAP_RIGHT = 2'd2;
    localparam logic [1:0] CAP_ALL   = 2'd3;

    // Sound mask bits
    localparam logic [2:0] SND_TRANS  = 3'b001;
    localparam logic [2:0] SND_WARN   = 3'b010;
    localparam logic [2:0] SND_REJECT = 3'b100;

    typedef struct packed {
        logic       kind;
        logic [1:0] device;
        logic       menu_pressed;
        logic       avatar_alive;
        logic       tracker_connected;
        logic [2:0] avatar_state;
        logic [2:0] button;
        logic       button_rejected;
        logic       left_arm_ready;
        logic       right_arm_ready;
    } t_in_req;

    typedef struct packed {
        logic [2:0] mode_now;
        logic [2:0] state_request;
        logic [2:0] arm_message;
        logic [1:0] capture_origins;
        logic       send_left_arm;
        logic       send_right_arm;
        logic       send_head;
        logic [2:0] sound_mask;
        logic [1:0] recovering_flags;
        logic [4:0] button_locks;
        logic [1:0] label_select;
    } t_out_rsp;

    typedef struct packed {
        t_mode mode;
        logic  left_rec;
        logic  right_rec;
        logic  head_origin_valid;
    } t_state;

endpackage

// File: rtl/core/tsmode_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session mode controller channels
// Valid/ready request and response channels with packed payloads.
// ----------------------------------------------------------------------------
interface tsmode_in_if
    import tsmode_pkg::*;
;
    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tsmode_out_if
    import tsmode_pkg::*;
;
    logic     valid;
    logic     ready;
    t_out_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tsmode_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session mode step logic
// Next state and response for one request, from the current state.
// ----------------------------------------------------------------------------
module tsmode_step
    import tsmode_pkg::*;
(
    input  t_state   i_state,
    input  t_in_req  i_req,
    output t_state   o_state,
    output t_out_rsp o_rsp
);

    logic   rst_hit;
    t_state n_st;
    logic   can_reset;
    logic   any_rec;

    // reset press taken in engaged or paused
    assign rst_hit = (i_req.button == B_RESET_L && !i_state.left_rec)
                  || (i_req.button == B_RESET_R && !i_state.right_rec)
                  || (i_req.button == B_RESET_ALL);

    always_comb begin
        n_st  = i_state;
        o_rsp = '0;

        if (i_req.kind) begin
            if (i_req.device == DEV_LEFT) begin
                o_rsp.capture_origins = CAP_LEFT;
                o_rsp.arm_message     = MSG_RESUME_L;
                n_st.left_rec         = 1'b0;
            end else if (i_req.device == DEV_RIGHT) begin
                o_rsp.capture_origins = CAP_RIGHT;
                o_rsp.arm_message     = MSG_RESUME_R;
                n_st.right_rec        = 1'b0;
            end
            o_rsp.sound_mask = SND_TRANS;
        end else if (i_state.mode != M_OFFLINE && i_state.mode != M_IDLE
                     && i_req.menu_pressed) begin
            // emergency stop
            o_rsp.sound_mask    = SND_WARN | SND_TRANS;
            o_rsp.state_request = REQ_IDLE;
            n_st.mode           = M_IDLE;
        end else if (i_state.mode != M_OFFLINE && !i_req.avatar_alive) begin
            o_rsp.sound_mask = SND_WARN | SND_TRANS;
            n_st.mode        = M_OFFLINE;
        end else begin
            if (i_req.button_rejected) begin
                o_rsp.sound_mask = SND_REJECT;
            end
            unique case (i_state.mode)
                M_OFFLINE: begin
                    if (i_req.avatar_alive && i_req.tracker_connected) begin
                        n_st.mode        = M_IDLE;
                        o_rsp.sound_mask = o_rsp.sound_mask | SND_TRANS;
                    end
                end
                M_IDLE: begin
                    if (i_req.button == B_START) begin
                        o_rsp.state_request = REQ_HOMING;
                        n_st.mode           = M_HOMING;
                        o_rsp.sound_mask    = o_rsp.sound_mask | SND_TRANS;
                    end
                end
                M_HOMING: begin
                    if (i_req.button == B_START) begin
                        o_rsp.state_request = REQ_IDLE;
                        n_st.mode           = M_IDLE;
                        o_rsp.sound_mask    = o_rsp.sound_mask | SND_TRANS;
                    end else if (i_req.avatar_state == M_AWAITING) begin
                        o_rsp.capture_origins  = CAP_ALL;
                        n_st.head_origin_valid = 1'b1;
                        n_st.mode              = M_AWAITING;
                        o_rsp.sound_mask       = o_rsp.sound_mask | SND_TRANS;
                    end
                end
                M_AWAITING, M_PAUSED: begin
                    if (i_req.button == B_START) begin
                        o_rsp.state_request = REQ_IDLE;
                        n_st.mode           = M_IDLE;
                        o_rsp.sound_mask    = o_rsp.sound_mask | SND_TRANS;
                    end else if (i_req.button == B_ENGAGE) begin
                        o_rsp.capture_origins  = CAP_ALL;
                        n_st.head_origin_valid = 1'b1;
                        o_rsp.state_request    = REQ_ENGAGED;
                        n_st.mode              = M_ENGAGED;
                        o_rsp.sound_mask       = o_rsp.sound_mask | SND_TRANS;
                    end else if (i_state.mode == M_PAUSED && rst_hit) begin
                        priority if (i_req.button == B_RESET_ALL) begin
                            o_rsp.arm_message = MSG_RESET_AL;
                            n_st.left_rec     = 1'b1;
                            n_st.right_rec    = 1'b1;
                        end else if (i_req.button == B_RESET_L) begin
                            o_rsp.arm_message = MSG_RESET_L;
                            n_st.left_rec     = 1'b1;
                        end else begin
                            o_rsp.arm_message = MSG_RESET_R;
                            n_st.right_rec    = 1'b1;
                        end
                    end
                end
                M_ENGAGED: begin
                    if (i_req.button == B_START) begin
                        o_rsp.state_request = REQ_IDLE;
                        n_st.mode           = M_IDLE;
                        o_rsp.sound_mask    = o_rsp.sound_mask | SND_TRANS;
                    end else if (i_req.button == B_ENGAGE) begin
                        o_rsp.state_request = REQ_PAUSED;
                        n_st.mode           = M_PAUSED;
                        o_rsp.sound_mask    = o_rsp.sound_mask | SND_TRANS;
                    end else if (rst_hit) begin
                        priority if (i_req.button == B_RESET_ALL) begin
                            o_rsp.arm_message = MSG_RESET_AL;
                            n_st.left_rec     = 1'b1;
                            n_st.right_rec    = 1'b1;
                        end else if (i_req.button == B_RESET_L) begin
                            o_rsp.arm_message = MSG_RESET_L;
                            n_st.left_rec     = 1'b1;
                        end else begin
                            o_rsp.arm_message = MSG_RESET_R;
                            n_st.right_rec    = 1'b1;
                        end
                    end else if (i_req.avatar_state == M_AWAITING) begin
                        o_rsp.capture_origins  = CAP_ALL;
                        n_st.head_origin_valid = 1'b1;
                        n_st.mode              = M_AWAITING;
                        o_rsp.sound_mask       = o_rsp.sound_mask | SND_TRANS;
                    end else begin
                        o_rsp.send_left_arm  = !i_state.left_rec && i_req.left_arm_ready;
                        o_rsp.send_right_arm = !i_state.right_rec && i_req.right_arm_ready;
                        o_rsp.send_head      = i_state.head_origin_valid;
                    end
                end
                default: begin
                end
            endcase
        end

        // locks and labels follow the state after the step
        can_reset = (n_st.mode == M_ENGAGED) || (n_st.mode == M_PAUSED);
        any_rec   = n_st.left_rec || n_st.right_rec;
        unique case (n_st.mode)
            M_OFFLINE: begin
                o_rsp.button_locks = 5'b00011;
                o_rsp.label_select = 2'b00;
            end
            M_IDLE: begin
                o_rsp.button_locks = 5'b00010;
                o_rsp.label_select = 2'b00;
            end
            M_HOMING: begin
                o_rsp.button_locks = 5'b00010;
                o_rsp.label_select = 2'b01;
            end
            M_AWAITING: begin
                o_rsp.button_locks = 5'b00000;
                o_rsp.label_select = 2'b01;
            end
            M_ENGAGED: begin
                o_rsp.button_locks = any_rec ? 5'b00011 : 5'b00000;
                o_rsp.label_select = 2'b11;
            end
            M_PAUSED: begin
                o_rsp.button_locks = any_rec ? 5'b00011 : 5'b00000;
                o_rsp.label_select = 2'b01;
            end
            default: begin
                o_rsp.button_locks = 5'b00011;
                o_rsp.label_select = 2'b00;
            end
        endcase
        o_rsp.button_locks[2] = n_st.left_rec || !can_reset;
        o_rsp.button_locks[3] = n_st.right_rec || !can_reset;
        o_rsp.button_locks[4] = !can_reset || any_rec;

        o_rsp.mode_now         = n_st.mode;
        o_rsp.recovering_flags = {n_st.right_rec, n_st.left_rec};
    end

    assign o_state = n_st;

endmodule

// File: rtl/core/teleop_session_mode_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Teleoperation session mode controller
// Operator-side mode sequencer for a two-arm teleoperation rig.
// ----------------------------------------------------------------------------
// Each request (an update tick or an arm reset-complete event) yields exactly
// one response. A request is captured into an input register, then one pass of
// step logic against the mode/recovery state produces the response, which is
// held in an output register while the state is updated in the same cycle.
// The response is registered in the output register when the request moves on
// from the input register, and can then be taken; throughput is one
// request per cycle, limited only by the output register being drained. The
// input side stays ready while a finished response waits, as long as the
// input register itself can move forward. After reset the mode is offline,
// both arms are not recovering and the head origin is not yet captured.
module teleop_session_mode_controller
    import tsmode_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    tsmode_in_if.sink           i_in,
    tsmode_out_if.source        o_out
);

    // input stage
    logic     r_in_vld;
    t_in_req  r_in;
    // session state
    t_state   r_state;
    t_state   n_state;
    // output stage
    logic     r_out_vld;
    t_out_rsp r_out;
    t_out_rsp n_out;

    logic     adv;      // input stage moves into output stage
    logic     in_take;

    assign adv     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;
    assign in_take = i_in.valid && i_in.ready;

    tsmode_step u_step (
        .i_state (r_state),
        .i_req   (r_in),
        .o_state (n_state),
        .o_rsp   (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in.data;
        end
    end

    // state and output register, updated together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '{mode: M_OFFLINE, left_rec: 1'b0, right_rec: 1'b0,
                           head_origin_valid: 1'b0};
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_state   <= n_state;
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_state))
        else $error("state changed without a request advancing");

    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced request produced no response");

    a_mode_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.mode_now == r_state.mode))
        else $error("response mode differs from state");

    a_rec_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.recovering_flags == {r_state.right_rec, r_state.left_rec}))
        else $error("response recovering flags differ from state");

    a_send_engaged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.send_left_arm || r_out.send_right_arm || r_out.send_head))
        |-> (r_out.mode_now == M_ENGAGED))
        else $error("pose send outside engaged mode");

endmodule
